>>> design/i2cps_pkg.sv
// package for the i2c master phase sequencer: beat types, opcodes and the
// microcode rom that spells out the bus phases of every command
// no dependencies
`timescale 1ns / 1ps

package i2cps_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE);
   localparam int STEP_W        = 5;

   localparam logic [3:0] HOLD_SHORT = 4'd2;
   localparam logic [3:0] HOLD_SETUP = 4'd5;
   localparam logic [3:0] HOLD_LONG  = 4'd10;

   typedef enum logic [2:0] {
      OP_START    = 3'd0,
      OP_STOP     = 3'd1,
      OP_WRITE    = 3'd2,
      OP_READ     = 3'd3,
      OP_SEND_ACK = 3'd4,
      OP_RECV_ACK = 3'd5
   } op_type;

   // where sda comes from in a phase
   typedef enum logic [1:0] {
      SDA_LOW  = 2'd0,
      SDA_HIGH = 2'd1,
      SDA_DATA = 2'd2,
      SDA_ACK  = 2'd3
   } sda_sel_type;

   typedef enum logic [1:0] {
      JMP_NEXT         = 2'd0,
      JMP_END          = 2'd1,
      JMP_LOOP_OR_NEXT = 2'd2,
      JMP_LOOP_OR_END  = 2'd3
   } jump_type;

   typedef struct packed {
      logic              scl;
      sda_sel_type       sda;
      logic [3:0]        hold;
      logic              sample;
      logic              advance;
      logic              rpt_rx;
      logic              rpt_ack;
      jump_type          jump;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] tx_byte;
      logic       ack_level;
      logic [7:0] target_sda_bits;
   } req_beat_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic [3:0] hold_us;
      logic       sample_taken;
      logic [7:0] rx_byte;
      logic       ack_seen;
      logic       last_phase;
   } rsp_beat_type;

   localparam logic [STEP_W-1:0] EP_START    = 5'd0;
   localparam logic [STEP_W-1:0] EP_STOP     = 5'd3;
   localparam logic [STEP_W-1:0] EP_WRITE    = 5'd6;
   localparam logic [STEP_W-1:0] EP_READ     = 5'd9;
   localparam logic [STEP_W-1:0] EP_READ_BIT = 5'd10;
   localparam logic [STEP_W-1:0] EP_SEND_ACK = 5'd13;
   localparam logic [STEP_W-1:0] EP_RECV_ACK = 5'd16;

   // fields: scl, sda, hold, sample, advance, rpt_rx, rpt_ack, jump, target
   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] addr);
      ctrl_word_type cw;
      unique case (addr)
         // start
         5'd0:  cw = '{1'b1, SDA_HIGH, HOLD_SETUP, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT, 5'd0};
         5'd1:  cw = '{1'b1, SDA_LOW,  HOLD_SETUP, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT, 5'd0};
         5'd2:  cw = '{1'b0, SDA_LOW,  HOLD_SHORT, 1'b0, 1'b0, 1'b0, 1'b0, JMP_END,  5'd0};
         // stop
         5'd3:  cw = '{1'b0, SDA_LOW,  HOLD_SETUP, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT, 5'd0};
         5'd4:  cw = '{1'b1, SDA_LOW,  HOLD_SETUP, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT, 5'd0};
         5'd5:  cw = '{1'b1, SDA_HIGH, HOLD_LONG,  1'b0, 1'b0, 1'b0, 1'b0, JMP_END,  5'd0};
         // write byte, msb first
         5'd6:  cw = '{1'b0, SDA_DATA, HOLD_SHORT, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT, 5'd0};
         5'd7:  cw = '{1'b1, SDA_DATA, HOLD_SETUP, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT, 5'd0};
         5'd8:  cw = '{1'b0, SDA_DATA, HOLD_SHORT, 1'b0, 1'b1, 1'b0, 1'b0,
                      JMP_LOOP_OR_END, EP_WRITE};
         // read byte
         5'd9:  cw = '{1'b0, SDA_HIGH, HOLD_SHORT, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT, 5'd0};
         5'd10: cw = '{1'b1, SDA_HIGH, HOLD_SETUP, 1'b1, 1'b0, 1'b0, 1'b0, JMP_NEXT, 5'd0};
         5'd11: cw = '{1'b0, SDA_HIGH, HOLD_SHORT, 1'b0, 1'b1, 1'b0, 1'b0,
                      JMP_LOOP_OR_NEXT, EP_READ_BIT};
         5'd12: cw = '{1'b0, SDA_HIGH, HOLD_SHORT, 1'b0, 1'b0, 1'b1, 1'b0, JMP_END,  5'd0};
         // send ack
         5'd13: cw = '{1'b0, SDA_ACK,  HOLD_SHORT, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT, 5'd0};
         5'd14: cw = '{1'b1, SDA_ACK,  HOLD_SETUP, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT, 5'd0};
         5'd15: cw = '{1'b0, SDA_ACK,  HOLD_SHORT, 1'b0, 1'b0, 1'b0, 1'b0, JMP_END,  5'd0};
         // receive ack
         5'd16: cw = '{1'b0, SDA_HIGH, HOLD_SETUP, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT, 5'd0};
         5'd17: cw = '{1'b1, SDA_HIGH, HOLD_SETUP, 1'b1, 1'b0, 1'b0, 1'b0, JMP_NEXT, 5'd0};
         5'd18: cw = '{1'b0, SDA_HIGH, HOLD_SETUP, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT, 5'd0};
         5'd19: cw = '{1'b0, SDA_HIGH, HOLD_SHORT, 1'b0, 1'b0, 1'b0, 1'b1, JMP_END,  5'd0};
         default: cw = '{1'b1, SDA_HIGH, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, JMP_END, 5'd0};
      endcase
      return cw;
   endfunction

endpackage

>>> design/i2c_master_phase_sequencer.sv
// Takes one I2C master command per start beat while busy is low and emits
// its bus phases, one rsp_strobe beat per clock: start, stop and send ack give
// 3 beats, receive ack 4, read byte 18 and write byte 24. The edge that takes
// the command loads the microcode step counter; the phase that the counter
// selects is then registered onto the ports as the first beat. Busy stays high
// until the last phase has been registered, and the next command can be
// taken once busy is low, while the last beat is still on the ports. Beats
// cannot be held off by the receiver. Opcodes six and seven give no beats.
// depends on i2cps_pkg
`timescale 1ns / 1ps

module i2c_master_phase_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  i2cps_pkg::req_beat_type req_item,
   output logic                   rsp_strobe,
   output i2cps_pkg::rsp_beat_type rsp_item
);

   logic                                run_ff, run_in;
   logic [i2cps_pkg::STEP_W-1:0]        pc_ff, pc_in;
   logic [i2cps_pkg::BIT_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [7:0]                          data_ff, data_in;
   logic [7:0]                          rx_ff, rx_in;
   logic                                ack_ff, ack_in;
   logic                                strobe_ff, strobe_in;
   i2cps_pkg::rsp_beat_type             rsp_ff, rsp_in;

   i2cps_pkg::ctrl_word_type            cw;
   logic                                accept;
   logic                                final_bit;
   logic                                entry_ok;
   logic [i2cps_pkg::STEP_W-1:0]        entry_pc;

   assign accept = start && !run_ff;
   assign cw     = i2cps_pkg::ucode_rom(pc_ff);
   assign final_bit = (cnt_ff == '0);

   always_comb begin
      entry_ok = 1'b1;
      entry_pc = i2cps_pkg::EP_START;
      unique case (req_item.op)
         i2cps_pkg::OP_START:    entry_pc = i2cps_pkg::EP_START;
         i2cps_pkg::OP_STOP:     entry_pc = i2cps_pkg::EP_STOP;
         i2cps_pkg::OP_WRITE:    entry_pc = i2cps_pkg::EP_WRITE;
         i2cps_pkg::OP_READ:     entry_pc = i2cps_pkg::EP_READ;
         i2cps_pkg::OP_SEND_ACK: entry_pc = i2cps_pkg::EP_SEND_ACK;
         i2cps_pkg::OP_RECV_ACK: entry_pc = i2cps_pkg::EP_RECV_ACK;
         default:                entry_ok = 1'b0;
      endcase
   end

   always_comb begin
      run_in    = run_ff;
      pc_in     = pc_ff;
      cnt_in    = cnt_ff;
      data_in   = data_ff;
      rx_in     = rx_ff;
      ack_in    = ack_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;

      if (accept) begin
         run_in  = entry_ok;
         pc_in   = entry_pc;
         cnt_in  = i2cps_pkg::BIT_CNT_W'(i2cps_pkg::BITS_PER_BYTE - 1);
         data_in = (req_item.op == i2cps_pkg::OP_WRITE) ? req_item.tx_byte
                                                        : req_item.target_sda_bits;
         ack_in  = req_item.ack_level;
      end else if (run_ff) begin
         strobe_in           = 1'b1;
         rsp_in.scl_level    = cw.scl;
         unique case (cw.sda)
            i2cps_pkg::SDA_LOW:  rsp_in.sda_level = 1'b0;
            i2cps_pkg::SDA_HIGH: rsp_in.sda_level = 1'b1;
            i2cps_pkg::SDA_DATA: rsp_in.sda_level = data_ff[7];
            i2cps_pkg::SDA_ACK:  rsp_in.sda_level = ack_ff;
            default:             rsp_in.sda_level = 1'b1;
         endcase
         rsp_in.hold_us      = cw.hold;
         rsp_in.sample_taken = cw.sample;
         rsp_in.rx_byte      = cw.rpt_rx ? rx_ff : 8'd0;
         rsp_in.ack_seen     = cw.rpt_ack ? rx_ff[0] : 1'b0;
         rsp_in.last_phase   = 1'b0;

         // sampled target level shifts into the receive register
         if (cw.sample) begin
            rx_in = {rx_ff[6:0], data_ff[7]};
         end
         if (cw.advance) begin
            data_in = {data_ff[6:0], 1'b0};
            cnt_in  = cnt_ff - 1'b1;
         end

         unique case (cw.jump)
            i2cps_pkg::JMP_NEXT: begin
               pc_in = pc_ff + 1'b1;
            end
            i2cps_pkg::JMP_END: begin
               run_in            = 1'b0;
               rsp_in.last_phase = 1'b1;
            end
            i2cps_pkg::JMP_LOOP_OR_NEXT: begin
               pc_in = final_bit ? pc_ff + 1'b1 : cw.target;
            end
            i2cps_pkg::JMP_LOOP_OR_END: begin
               pc_in = cw.target;
               if (final_bit) begin
                  run_in            = 1'b0;
                  rsp_in.last_phase = 1'b1;
               end
            end
            default: begin
               run_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         strobe_ff <= 1'b0;
         pc_ff     <= '0;
         cnt_ff    <= '0;
      end else begin
         run_ff    <= run_in;
         strobe_ff <= strobe_in;
         pc_ff     <= pc_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      rx_ff   <= rx_in;
      ack_ff  <= ack_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = run_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

>>> tb/i2c_master_phase_sequencer_tb.sv
// testbench for i2c_master_phase_sequencer: predicts the bus phases of every
// command and checks each rsp beat in order, with random start gaps
// depends on i2cps_pkg and the sequencer rtl
`timescale 1ns / 1ps

module i2c_master_phase_sequencer_tb;

   // opcodes the block must ignore
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   localparam int CYCLE_LIMIT = 40000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_COMMANDS = 90;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   i2cps_pkg::req_beat_type req_item;
   logic                    rsp_strobe;
   i2cps_pkg::rsp_beat_type rsp_item;

   i2cps_pkg::rsp_beat_type bus_phase_q[$];
   i2cps_pkg::rsp_beat_type want_phase;
   int                      mismatch_count;
   int                      beat_count;
   int                      cycle_count;
   int                      max_gap;
   int                      commands_sent;

   i2c_master_phase_sequencer u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic void push_phase(input logic scl, input logic sda,
                                      input logic [3:0] hold, input logic smp,
                                      input logic [7:0] rx, input logic ack,
                                      input logic last);
      i2cps_pkg::rsp_beat_type ph;
      ph.scl_level    = scl;
      ph.sda_level    = sda;
      ph.hold_us      = hold;
      ph.sample_taken = smp;
      ph.rx_byte      = rx;
      ph.ack_seen     = ack;
      ph.last_phase   = last;
      bus_phase_q.push_back(ph);
   endfunction

   function automatic void predict_bus_phases(input i2cps_pkg::req_beat_type cmd);
      logic [7:0] rx_acc;
      logic       bit_val;
      rx_acc = '0;
      case (cmd.op)
         i2cps_pkg::OP_START: begin
            push_phase(1'b1, 1'b1, i2cps_pkg::HOLD_SETUP, 1'b0, 8'h00, 1'b0, 1'b0);
            push_phase(1'b1, 1'b0, i2cps_pkg::HOLD_SETUP, 1'b0, 8'h00, 1'b0, 1'b0);
            push_phase(1'b0, 1'b0, i2cps_pkg::HOLD_SHORT, 1'b0, 8'h00, 1'b0, 1'b1);
         end
         i2cps_pkg::OP_STOP: begin
            push_phase(1'b0, 1'b0, i2cps_pkg::HOLD_SETUP, 1'b0, 8'h00, 1'b0, 1'b0);
            push_phase(1'b1, 1'b0, i2cps_pkg::HOLD_SETUP, 1'b0, 8'h00, 1'b0, 1'b0);
            push_phase(1'b1, 1'b1, i2cps_pkg::HOLD_LONG,  1'b0, 8'h00, 1'b0, 1'b1);
         end
         i2cps_pkg::OP_WRITE: begin
            for (int i = 0; i < i2cps_pkg::BITS_PER_BYTE; i++) begin
               bit_val = cmd.tx_byte[i2cps_pkg::BITS_PER_BYTE-1-i];
               push_phase(1'b0, bit_val, i2cps_pkg::HOLD_SHORT, 1'b0, 8'h00, 1'b0,
                          1'b0);
               push_phase(1'b1, bit_val, i2cps_pkg::HOLD_SETUP, 1'b0, 8'h00, 1'b0,
                          1'b0);
               push_phase(1'b0, bit_val, i2cps_pkg::HOLD_SHORT, 1'b0, 8'h00, 1'b0,
                          (i == i2cps_pkg::BITS_PER_BYTE - 1));
            end
         end
         i2cps_pkg::OP_READ: begin
            push_phase(1'b0, 1'b1, i2cps_pkg::HOLD_SHORT, 1'b0, 8'h00, 1'b0, 1'b0);
            for (int i = 0; i < i2cps_pkg::BITS_PER_BYTE; i++) begin
               rx_acc = {rx_acc[6:0],
                         cmd.target_sda_bits[i2cps_pkg::BITS_PER_BYTE-1-i]};
               push_phase(1'b1, 1'b1, i2cps_pkg::HOLD_SETUP, 1'b1, 8'h00, 1'b0,
                          1'b0);
               push_phase(1'b0, 1'b1, i2cps_pkg::HOLD_SHORT, 1'b0, 8'h00, 1'b0,
                          1'b0);
            end
            push_phase(1'b0, 1'b1, i2cps_pkg::HOLD_SHORT, 1'b0, rx_acc, 1'b0, 1'b1);
         end
         i2cps_pkg::OP_SEND_ACK: begin
            push_phase(1'b0, cmd.ack_level, i2cps_pkg::HOLD_SHORT, 1'b0, 8'h00,
                       1'b0, 1'b0);
            push_phase(1'b1, cmd.ack_level, i2cps_pkg::HOLD_SETUP, 1'b0, 8'h00,
                       1'b0, 1'b0);
            push_phase(1'b0, cmd.ack_level, i2cps_pkg::HOLD_SHORT, 1'b0, 8'h00,
                       1'b0, 1'b1);
         end
         i2cps_pkg::OP_RECV_ACK: begin
            push_phase(1'b0, 1'b1, i2cps_pkg::HOLD_SETUP, 1'b0, 8'h00, 1'b0, 1'b0);
            push_phase(1'b1, 1'b1, i2cps_pkg::HOLD_SETUP, 1'b1, 8'h00, 1'b0, 1'b0);
            push_phase(1'b0, 1'b1, i2cps_pkg::HOLD_SETUP, 1'b0, 8'h00, 1'b0, 1'b0);
            push_phase(1'b0, 1'b1, i2cps_pkg::HOLD_SHORT, 1'b0, 8'h00,
                       cmd.target_sda_bits[7], 1'b1);
         end
         default: ;  // spare opcodes put nothing on the bus
      endcase
   endfunction

   // ---------------------------------------------------------------- checker

   task automatic report_mismatch(input string field, input logic [7:0] want,
                                  input logic [7:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("beat %0d: %s expected %0h got %0h", beat_count, field, want, got);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (bus_phase_q.size() == 0) begin
            report_mismatch("unexpected beat, scl/sda", 8'h00,
                            {6'd0, rsp_item.scl_level, rsp_item.sda_level});
         end else begin
            want_phase = bus_phase_q.pop_front();
            if (rsp_item.scl_level !== want_phase.scl_level)
               report_mismatch("scl_level", {7'd0, want_phase.scl_level},
                               {7'd0, rsp_item.scl_level});
            if (rsp_item.sda_level !== want_phase.sda_level)
               report_mismatch("sda_level", {7'd0, want_phase.sda_level},
                               {7'd0, rsp_item.sda_level});
            if (rsp_item.hold_us !== want_phase.hold_us)
               report_mismatch("hold_us", {4'd0, want_phase.hold_us},
                               {4'd0, rsp_item.hold_us});
            if (rsp_item.sample_taken !== want_phase.sample_taken)
               report_mismatch("sample_taken", {7'd0, want_phase.sample_taken},
                               {7'd0, rsp_item.sample_taken});
            if (rsp_item.rx_byte !== want_phase.rx_byte)
               report_mismatch("rx_byte", want_phase.rx_byte, rsp_item.rx_byte);
            if (rsp_item.ack_seen !== want_phase.ack_seen)
               report_mismatch("ack_seen", {7'd0, want_phase.ack_seen},
                               {7'd0, rsp_item.ack_seen});
            if (rsp_item.last_phase !== want_phase.last_phase)
               report_mismatch("last_phase", {7'd0, want_phase.last_phase},
                               {7'd0, rsp_item.last_phase});
         end
         beat_count++;
      end
   end

   // ---------------------------------------------------------------- driver

   function automatic i2cps_pkg::req_beat_type make_cmd(input logic [2:0] op);
      i2cps_pkg::req_beat_type cmd;
      cmd.op              = op;
      cmd.tx_byte         = 8'($urandom_range(0, 255));
      cmd.ack_level       = 1'($urandom_range(0, 1));
      cmd.target_sda_bits = 8'($urandom_range(0, 255));
      return cmd;
   endfunction

   // called right after a rising edge; returns at the edge that takes the beat
   task automatic send_command(input i2cps_pkg::req_beat_type cmd, input bit drain);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (drain || gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         if (drain) begin
            @(posedge clock);
            while (bus_phase_q.size() != 0) @(posedge clock);
         end
      end
      start    <= 1'b1;
      req_item <= cmd;
      do @(posedge clock); while (busy);
      predict_bus_phases(cmd);
      if (cmd.op <= i2cps_pkg::OP_RECV_ACK)
         commands_sent++;
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_each_command();
      i2cps_pkg::req_beat_type cmd;
      max_gap = 2;
      send_command(make_cmd(i2cps_pkg::OP_START), 1'b0);
      send_command(make_cmd(i2cps_pkg::OP_STOP), 1'b0);
      cmd = make_cmd(i2cps_pkg::OP_WRITE);  cmd.tx_byte = 8'h00;  send_command(cmd, 1'b0);
      cmd = make_cmd(i2cps_pkg::OP_WRITE);  cmd.tx_byte = 8'hFF;  send_command(cmd, 1'b0);
      cmd = make_cmd(i2cps_pkg::OP_WRITE);  cmd.tx_byte = 8'hA5;  send_command(cmd, 1'b0);
      cmd = make_cmd(i2cps_pkg::OP_READ);  cmd.target_sda_bits = 8'h00;
      send_command(cmd, 1'b0);
      cmd = make_cmd(i2cps_pkg::OP_READ);  cmd.target_sda_bits = 8'hFF;
      send_command(cmd, 1'b0);
      cmd = make_cmd(i2cps_pkg::OP_READ);  cmd.target_sda_bits = 8'h5A;
      send_command(cmd, 1'b0);
      cmd = make_cmd(i2cps_pkg::OP_SEND_ACK);  cmd.ack_level = 1'b0;
      send_command(cmd, 1'b0);
      cmd = make_cmd(i2cps_pkg::OP_SEND_ACK);  cmd.ack_level = 1'b1;
      send_command(cmd, 1'b0);
      // only bit 7 of the target levels matters for receive ack
      cmd = make_cmd(i2cps_pkg::OP_RECV_ACK);  cmd.target_sda_bits = 8'h7F;
      send_command(cmd, 1'b0);
      cmd = make_cmd(i2cps_pkg::OP_RECV_ACK);  cmd.target_sda_bits = 8'h80;
      send_command(cmd, 1'b0);
      // stop right after start, then stop again with the bus already released
      send_command(make_cmd(i2cps_pkg::OP_START), 1'b0);
      send_command(make_cmd(i2cps_pkg::OP_STOP), 1'b0);
      send_command(make_cmd(i2cps_pkg::OP_STOP), 1'b0);
   endtask

   task automatic test_spare_opcodes();
      max_gap = 3;
      send_command(make_cmd(OP_SPARE_6), 1'b0);
      send_command(make_cmd(OP_SPARE_7), 1'b0);
      send_command(make_cmd(i2cps_pkg::OP_START), 1'b0);
      send_command(make_cmd(OP_SPARE_7), 1'b0);
      send_command(make_cmd(OP_SPARE_6), 1'b0);
      send_command(make_cmd(i2cps_pkg::OP_STOP), 1'b0);
   endtask

   task automatic test_drain_pause();
      max_gap = 6;
      send_command(make_cmd(i2cps_pkg::OP_START), 1'b1);
      send_command(make_cmd(i2cps_pkg::OP_WRITE), 1'b1);
      send_command(make_cmd(i2cps_pkg::OP_RECV_ACK), 1'b1);
      send_command(make_cmd(i2cps_pkg::OP_STOP), 1'b1);
   endtask

   // well-formed transfers with random content, plus stray and cut-off ones
   task automatic test_random_transfers();
      i2cps_pkg::req_beat_type addr;
      int                      n_bytes;
      int                      goal;
      goal = commands_sent + RANDOM_COMMANDS;
      while (commands_sent < goal) begin
         max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
         if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 3))
               send_command(make_cmd(3'($urandom_range(0, 7))), 1'b0);
         end else begin
            send_command(make_cmd(i2cps_pkg::OP_START), $urandom_range(0, 9) == 0);
            addr = make_cmd(i2cps_pkg::OP_WRITE);
            send_command(addr, 1'b0);
            send_command(make_cmd(i2cps_pkg::OP_RECV_ACK), 1'b0);
            n_bytes = $urandom_range(1, 4);
            for (int k = 0; k < n_bytes; k++) begin
               if (addr.tx_byte[0]) begin
                  send_command(make_cmd(i2cps_pkg::OP_READ), 1'b0);
                  send_command(make_cmd(i2cps_pkg::OP_SEND_ACK), 1'b0);
               end else begin
                  send_command(make_cmd(i2cps_pkg::OP_WRITE), 1'b0);
                  send_command(make_cmd(i2cps_pkg::OP_RECV_ACK), 1'b0);
               end
            end
            // now and then leave the transfer open
            if ($urandom_range(0, 7) != 0)
               send_command(make_cmd(i2cps_pkg::OP_STOP), 1'b0);
         end
      end
   endtask

   // ---------------------------------------------------------------- main

   initial begin
      mismatch_count = 0;
      beat_count     = 0;
      cycle_count    = 0;
      commands_sent  = 0;
      max_gap        = 0;
      start    <= 1'b0;
      req_item <= '0;
      reset    <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_each_command();
      test_spare_opcodes();
      test_drain_pause();
      test_random_transfers();

      start <= 1'b0;
      while (bus_phase_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (bus_phase_q.size() != 0)
         $display("%0d phases never arrived", bus_phase_q.size());
      if (mismatch_count == 0 && bus_phase_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
